// File: hdl/rlid_pkg.sv
// Shared types and constants for the run-length image decoder.
// Holds the controller/datapath command and status structs and header positions.
// No dependencies.
package rlid_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned COUNT_BITS = 4;
  localparam int unsigned HDR_BITS   = 3;
  localparam int unsigned WORD_BITS  = 16;

  // Bytes above this value are run markers.
  localparam logic [BYTE_BITS-1:0] MARKER_LIMIT = 8'hF0;

  // Header byte positions.
  localparam logic [HDR_BITS-1:0] HDR_WIDTH_LO  = 3'd4;
  localparam logic [HDR_BITS-1:0] HDR_WIDTH_HI  = 3'd5;
  localparam logic [HDR_BITS-1:0] HDR_HEIGHT_LO = 3'd6;
  localparam logic [HDR_BITS-1:0] HDR_HEIGHT_HI = 3'd7;

  typedef struct packed {
    logic hdr_take;     // store the accepted byte as a header byte
    logic hdr_restart;  // the accepted byte is header byte zero
    logic mult;         // load the pixel count from the dimensions
    logic lit_load;     // put the accepted byte out as one pixel
    logic run_arm;      // latch the run count from a marker
    logic run_load;     // latch the byte to repeat
    logic emit;         // put one copy of the run byte out
  } cmd_t;

  typedef struct packed {
    logic hdr_last;     // next header byte is the final one
    logic is_marker;    // accepted byte is a run marker
    logic dims_zero;    // width or height is zero
    logic pix_last;     // exactly one pixel left
    logic run_end;      // this emission closes the run
    logic out_free;     // output register can take a new item
  } status_t;

endpackage

// File: hdl/rle_image_decoder.sv
// Top level of the run-length image decoder.
// Instantiates rlid_ctrl and rlid_datapath; uses rlid_pkg.
//
// Input stream: one byte of the compressed lump per item on s_axis_tdata;
// s_axis_tuser = 1 marks the first header byte of a new image and restarts
// decoding from any point. The first 8 bytes form the header (type, unused
// word, width, height, little endian). Output stream: one decoded pixel per
// item on m_axis_tdata, with m_axis_tlast on the final pixel of the image.
// Bytes after the final pixel are dropped until the next header.
//
// Timing: after the last header byte the block multiplies width by height in
// a state of its own and takes no input. A run marker and then its byte are
// taken, then the run emits one pixel per cycle (up to 15) while the receiver
// takes them, with input held off. Output pixels are registered in the output
// register. The output register sets the pace: when the receiver stalls,
// literals and run emission hold.
// Reset empties the output register and returns the block to the header.
module rle_image_decoder #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] first_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] pixel
  output logic       m_axis_tlast    // last_pixel
);
  import rlid_pkg::*;

  cmd_t    cmd;
  status_t status;

  rlid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_first (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rlid_datapath #(
    .DIM_BITS (DIM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pixel (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: hdl/rlid_datapath.sv
// Datapath of the run-length image decoder: header fields, pixel and run
// counters and the output register. Driven by rlid_ctrl; uses rlid_pkg.
module rlid_datapath #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rlid_pkg::cmd_t           cmd,
  output rlid_pkg::status_t        status,
  input  logic [7:0]               in_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_pixel,
  output logic                     out_last
);
  import rlid_pkg::*;

  localparam int unsigned PIX_BITS = 2 * DIM_BITS;

  logic [HDR_BITS-1:0]   hdr_idx;
  logic [HDR_BITS-1:0]   hdr_pos;
  logic [WORD_BITS-1:0]  width;
  logic [WORD_BITS-1:0]  height;
  logic [DIM_BITS-1:0]   width_m;
  logic [DIM_BITS-1:0]   height_m;
  logic [PIX_BITS-1:0]   pixels_left;
  logic [COUNT_BITS-1:0] run_cnt;
  logic [BYTE_BITS-1:0]  run_byte;
  logic                  pix_last;

  assign hdr_pos  = cmd.hdr_restart ? '0 : hdr_idx;
  assign width_m  = width[DIM_BITS-1:0];
  assign height_m = height[DIM_BITS-1:0];
  assign pix_last = (pixels_left == PIX_BITS'(1));

  assign status.hdr_last  = (hdr_idx == HDR_HEIGHT_HI);
  assign status.is_marker = (in_byte > MARKER_LIMIT);
  assign status.dims_zero = (width_m == '0) || (height_m == '0);
  assign status.pix_last  = pix_last;
  assign status.run_end   = (run_cnt == COUNT_BITS'(1)) || pix_last;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx     <= '0;
      width       <= '0;
      height      <= '0;
      pixels_left <= '0;
      run_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.hdr_take) begin
        case (hdr_pos)
          HDR_WIDTH_LO:  width[7:0]   <= in_byte;
          HDR_WIDTH_HI:  width[15:8]  <= in_byte;
          HDR_HEIGHT_LO: height[7:0]  <= in_byte;
          HDR_HEIGHT_HI: height[15:8] <= in_byte;
          default: ;
        endcase
        hdr_idx <= hdr_pos + HDR_BITS'(1);
      end
      if (cmd.mult) begin
        pixels_left <= PIX_BITS'(width_m) * PIX_BITS'(height_m);
      end
      if (cmd.run_arm) begin
        run_cnt <= in_byte[COUNT_BITS-1:0];
      end
      if (cmd.lit_load) begin
        pixels_left <= pixels_left - PIX_BITS'(1);
      end
      if (cmd.emit) begin
        pixels_left <= pixels_left - PIX_BITS'(1);
        run_cnt     <= run_cnt - COUNT_BITS'(1);
      end
      if (cmd.lit_load || cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_load) begin
      run_byte <= in_byte;
    end
    if (cmd.lit_load) begin
      out_pixel <= in_byte;
      out_last  <= pix_last;
    end else if (cmd.emit) begin
      out_pixel <= run_byte;
      out_last  <= pix_last;
    end
  end

endmodule

// File: hdl/rlid_ctrl.sv
// Controller of the run-length image decoder: phase state machine, input
// ready and datapath commands. Uses rlid_pkg; drives rlid_datapath.
module rlid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_first,
  output logic              in_ready,
  input  rlid_pkg::status_t status,
  output rlid_pkg::cmd_t    cmd
);
  import rlid_pkg::*;

  localparam logic [2:0] ST_HEADER = 3'd0;
  localparam logic [2:0] ST_MULT   = 3'd1;
  localparam logic [2:0] ST_DATA   = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  always_comb begin
    case (state)
      ST_HEADER, ST_RUN, ST_DONE: in_ready = 1'b1;
      ST_DATA:                    in_ready = status.out_free;
      default:                    in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (accept && in_first) begin
      // restart the header from any phase, drop a pending run
      cmd.hdr_take    = 1'b1;
      cmd.hdr_restart = 1'b1;
      state_next      = ST_HEADER;
    end else begin
      case (state)
        ST_HEADER: begin
          if (accept) begin
            cmd.hdr_take = 1'b1;
            if (status.hdr_last) state_next = ST_MULT;
          end
        end
        ST_MULT: begin
          cmd.mult   = 1'b1;
          state_next = status.dims_zero ? ST_DONE : ST_DATA;
        end
        ST_DATA: begin
          if (accept) begin
            if (status.is_marker) begin
              cmd.run_arm = 1'b1;
              state_next  = ST_RUN;
            end else begin
              cmd.lit_load = 1'b1;
              if (status.pix_last) state_next = ST_DONE;
            end
          end
        end
        ST_RUN: begin
          if (accept) begin
            cmd.run_load = 1'b1;
            state_next   = ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (status.out_free) begin
            cmd.emit = 1'b1;
            if (status.run_end) state_next = status.pix_last ? ST_DONE : ST_DATA;
          end
        end
        ST_DONE: ;
        default: state_next = ST_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/rlid_checker.sv
// Port-level checks for the run-length image decoder, bound to the top level.
// Sees only the ports of rle_image_decoder.
module rlid_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // a header start never produces a pixel
  a_first_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !$rose(m_axis_tvalid))
    else $error("pixel produced by a header byte");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind rle_image_decoder rlid_checker u_rlid_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
